@@ hw/rtl/bounded_value_list_assert.svh @@
// Assertion macros used by the RTL datapath. Each expects clk and rst in scope.
`ifndef BOUNDED_VALUE_LIST_ASSERT_SVH
`define BOUNDED_VALUE_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_value_list: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BVL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_value_list: next-cycle check failed");

`endif

@@ hw/rtl/bvl_pkg.sv @@
`default_nettype none

package bvl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ACTION_W     = 3;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int LENGTH_W     = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_REM_MATCH = 3'd4,
    ACT_QUERY     = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    ins_front;
    logic    ins_back;
    logic    rem_front;
    logic    rem_back;
    logic    start_scan;
    logic    issue;
    logic    shift_wr;
    logic    commit_remove;
    logic    set_res;
    status_t res_status;
    logic    res_found;
    logic    load_out;
  } bvl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    empty;
    logic    full;
    logic    match;
    logic    scan_done;
    logic    out_free;
  } bvl_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bvl_intf.sv @@
`default_nettype none

interface bvl_req_if;
  import bvl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;
  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface bvl_rsp_if;
  import bvl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [LENGTH_W-1:0]  length;
  modport source (output valid, status, found, length, input ready);
  modport sink (input valid, status, found, length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bvl_ram.sv @@
`default_nettype none

module bvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvl_ctrl.sv @@
`default_nettype none

module bvl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire bvl_pkg::bvl_stat_t stat,
  output bvl_pkg::bvl_cmd_t       cmd
);
  import bvl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((stat.action == ACT_REM_MATCH || stat.action == ACT_QUERY) && !stat.empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        priority if (stat.match) begin
          state_next = (stat.action == ACT_REM_MATCH) ? ST_SHIFT : ST_FINISH;
        end else if (stat.scan_done) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SHIFT: begin
        if (stat.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = STS_OK;
        unique case (stat.action)
          ACT_INS_FRONT: begin
            if (stat.full) cmd.res_status = STS_FULL;
            else cmd.ins_front = 1'b1;
          end
          ACT_INS_BACK: begin
            if (stat.full) cmd.res_status = STS_FULL;
            else cmd.ins_back = 1'b1;
          end
          ACT_REM_FRONT: begin
            if (stat.empty) cmd.res_status = STS_EMPTY;
            else cmd.rem_front = 1'b1;
          end
          ACT_REM_BACK: begin
            if (stat.empty) cmd.res_status = STS_EMPTY;
            else cmd.rem_back = 1'b1;
          end
          ACT_REM_MATCH, ACT_QUERY: begin
            if (stat.empty) cmd.res_status = STS_EMPTY;
            else cmd.start_scan = 1'b1;
          end
          default: cmd.res_status = STS_OK;
        endcase
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        priority if (stat.match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STS_OK;
          cmd.res_found  = 1'b1;
        end else if (stat.scan_done) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STS_NOT_FOUND;
        end else begin
          cmd.set_res    = 1'b0;
        end
      end
      ST_SHIFT: begin
        cmd.issue         = 1'b1;
        cmd.shift_wr      = 1'b1;
        cmd.commit_remove = stat.scan_done;
      end
      ST_FINISH: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvl_datapath.sv @@
`default_nettype none
`include "bounded_value_list_assert.svh"

module bvl_datapath #(
  parameter int CAPACITY = bvl_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bvl_pkg::bvl_cmd_t                   cmd,
  output bvl_pkg::bvl_stat_t                       stat,
  input  wire logic [bvl_pkg::ACTION_W-1:0]        req_action,
  input  wire logic signed [bvl_pkg::VALUE_W-1:0]  req_value,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output logic [bvl_pkg::STATUS_W-1:0]             rsp_status,
  output logic                                     rsp_found,
  output logic [bvl_pkg::LENGTH_W-1:0]             rsp_length
);
  import bvl_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [AW:0]      CAP_WIDE  = (AW+1)'(CAPACITY);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_ADDR : p - AW'(1);
  endfunction

  logic [AW-1:0]      head;
  logic [CNT_W-1:0]   count;
  action_t            action_q;
  logic [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]   issue_idx;
  logic [AW-1:0]      rp;
  logic               rvalid;
  logic [AW-1:0]      raddr_q;
  status_t            res_status;
  logic               res_found;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [VALUE_W-1:0] rdata;
  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail;
  logic               issue_go;

  assign tail_sum = (AW+1)'(head) + (AW+1)'(count);
  assign tail     = (tail_sum >= CAP_WIDE) ? AW'(tail_sum - CAP_WIDE) : AW'(tail_sum);
  assign issue_go = cmd.issue && (issue_idx != count);

  always_comb begin
    we    = 1'b0;
    waddr = ptr_dec(head);
    wdata = value_q;
    priority if (cmd.ins_front) begin
      we = 1'b1;
    end else if (cmd.ins_back) begin
      we    = 1'b1;
      waddr = tail;
    end else if (cmd.shift_wr && rvalid) begin
      we    = 1'b1;
      waddr = ptr_dec(raddr_q);
      wdata = rdata;
    end else begin
      we = 1'b0;
    end
  end

  bvl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rp),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action_t'(req_action);
      value_q  <= req_value;
    end
    if (issue_go) begin
      raddr_q <= rp;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found;
    end
    if (cmd.start_scan) begin
      rp <= head;
    end else if (issue_go) begin
      rp <= ptr_inc(rp);
    end
    if (cmd.load_out) begin
      rsp_status <= res_status;
      rsp_found  <= res_found;
      rsp_length <= LENGTH_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      issue_idx <= '0;
      rvalid    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rvalid <= issue_go;
      if (cmd.ins_front) begin
        head <= ptr_dec(head);
      end else if (cmd.rem_front) begin
        head <= ptr_inc(head);
      end
      if (cmd.ins_front || cmd.ins_back) begin
        count <= count + CNT_W'(1);
      end else if (cmd.rem_front || cmd.rem_back || cmd.commit_remove) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.start_scan) begin
        issue_idx <= '0;
      end else if (issue_go) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.action    = action_q;
    stat.empty     = (count == '0);
    stat.full      = (count == CAP_CNT);
    stat.match     = rvalid && (rdata == value_q);
    stat.scan_done = !rvalid && (issue_idx == count);
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  `BVL_ASSERT_SAME(a_count_bound, 1'b1, count <= CAP_CNT)
  `BVL_ASSERT_SAME(a_issue_bound, cmd.issue, issue_idx <= count)
  `BVL_ASSERT_NEXT(a_commit_shrinks, cmd.commit_remove, count == $past(count) - CNT_W'(1))
  `BVL_ASSERT_NEXT(a_ins_front_head, cmd.ins_front, head == ptr_dec($past(head)))

endmodule

`default_nettype wire

@@ hw/rtl/bounded_value_list.sv @@
// Bounded list of signed 32-bit values, kept in order from front to back,
// with insert and remove at both ends and search by value.
// The request channel carries an action and a value; the result channel
// returns a status, a found flag and the list length after the action.
// Both channels use a valid/ready handshake; one result per request.
// Requests are handled one at a time. Insert and end removals go through
// capture, execute and result load from acceptance to result valid.
// Query and remove-by-value scan the entries through the single read port
// of the entry memory, one entry per cycle; a removal then moves each entry
// behind the match one place toward the front to close the gap.
// The entries sit in a circular buffer, so end operations never move data.
// A new request is accepted once the previous one has reached the result
// register, even while that result waits for the receiver. If the receiver
// stalls, the result holds and the next request waits before its own result.
// Synchronous reset empties the list at once; no clearing pass is needed.
`default_nettype none

module bounded_value_list #(
  parameter int CAPACITY = bvl_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bvl_req_if.sink    request,
  bvl_rsp_if.source  result
);
  import bvl_pkg::*;

  bvl_cmd_t  cmd;
  bvl_stat_t stat;

  bvl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bvl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_action (request.action),
    .req_value  (request.value),
    .rsp_valid  (result.valid),
    .rsp_ready  (result.ready),
    .rsp_status (result.status),
    .rsp_found  (result.found),
    .rsp_length (result.length)
  );

endmodule

`default_nettype wire
